@@ rtl/core/xtea_block_cipher_assert.svh @@
// ----------------------------------------------------------------------------
// XTEA block cipher assertion macros
// Concurrent checks that sample on clk and are disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef XTEA_BLOCK_CIPHER_ASSERT_SVH
`define XTEA_BLOCK_CIPHER_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define XTEA_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define XTEA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/xtea_pkg.sv @@
// ----------------------------------------------------------------------------
// XTEA package
// Shared types and constants of the XTEA block cipher pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package xtea_pkg;

    localparam int          XTEA_NUM_ROUNDS = 32;
    localparam logic [31:0] XTEA_DELTA      = 32'h9e37_79b9;
    localparam int          XTEA_KEY_WORDS  = 4;
    localparam int          XTEA_CFG_IDX_W  = 2;

    // opcode values
    localparam logic OP_ENCRYPT = 1'b0;
    localparam logic OP_DECRYPT = 1'b1;

    // configuration register indexes
    localparam logic [XTEA_CFG_IDX_W-1:0] REG_KEY_WORD0 = 2'd0;
    localparam logic [XTEA_CFG_IDX_W-1:0] REG_KEY_WORD1 = 2'd1;
    localparam logic [XTEA_CFG_IDX_W-1:0] REG_KEY_WORD2 = 2'd2;
    localparam logic [XTEA_CFG_IDX_W-1:0] REG_KEY_WORD3 = 2'd3;

    typedef logic [XTEA_KEY_WORDS-1:0][31:0] xtea_key_t;

    typedef struct packed {
        logic        opcode;
        logic [31:0] block_lo;
        logic [31:0] block_hi;
    } xtea_in_word_t;

    typedef struct packed {
        logic [31:0] out_lo;
        logic [31:0] out_hi;
    } xtea_out_word_t;

    // word state carried from cell to cell
    typedef struct packed {
        logic        opcode;
        logic [31:0] v0;
        logic [31:0] v1;
        logic [31:0] sum;
    } xtea_stage_t;

endpackage : xtea_pkg

`default_nettype wire

@@ rtl/core/xtea_round_cell.sv @@
// ----------------------------------------------------------------------------
// XTEA half-round cell
// One half of an XTEA round: update one half of the block from the other,
// registered, handing the word to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module xtea_round_cell
    import xtea_pkg::*;
#(
    parameter bit PHASE = 1'b0
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        adv,
    input  wire xtea_key_t   key,
    input  wire logic        prev_valid,
    input  wire xtea_stage_t prev_stage,
    output      logic        cur_valid,
    output      xtea_stage_t cur_stage
);

    logic        valid_reg;
    logic        valid_next;
    xtea_stage_t stage_reg;
    xtea_stage_t stage_next;

    logic        tgt_v1;
    logic [31:0] src;
    logic [31:0] tgt;
    logic [31:0] mix;
    logic [1:0]  kidx;
    logic [31:0] f_val;
    logic [31:0] tgt_new;

    always_comb
    begin
        // encrypt: first phase updates v0; decrypt swaps the order
        tgt_v1  = prev_stage.opcode ^ PHASE;
        src     = tgt_v1 ? prev_stage.v0 : prev_stage.v1;
        tgt     = tgt_v1 ? prev_stage.v1 : prev_stage.v0;
        kidx    = tgt_v1 ? prev_stage.sum[12:11] : prev_stage.sum[1:0];
        mix     = ((src << 4) ^ (src >> 5)) + src;
        f_val   = mix ^ (prev_stage.sum + key[kidx]);
        tgt_new = (prev_stage.opcode == OP_DECRYPT) ? (tgt - f_val) : (tgt + f_val);

        stage_next        = prev_stage;
        stage_next.v0     = tgt_v1 ? prev_stage.v0 : tgt_new;
        stage_next.v1     = tgt_v1 ? tgt_new : prev_stage.v1;
        if (PHASE == 1'b0)
        begin
            stage_next.sum = (prev_stage.opcode == OP_DECRYPT)
                           ? (prev_stage.sum - XTEA_DELTA)
                           : (prev_stage.sum + XTEA_DELTA);
        end
        valid_next = prev_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            stage_reg <= stage_next;
        end
    end

    assign cur_valid = valid_reg;
    assign cur_stage = stage_reg;

endmodule : xtea_round_cell

`default_nettype wire

@@ rtl/core/xtea_block_cipher.sv @@
// An accepted word passes through each cell register of the chain, then the output register.
// One word per cycle while the chain advances; a half-round cell per stage sets the clock path.
// The cell chain advances unless its last cell holds a word the stalled output can't take.
// Reset (rst_n low, asynchronous): all valid flags clear, key words return to zero.
// Key words are to be written by the user only while the pipeline is empty; no logic checks it.
// ----------------------------------------------------------------------------
// XTEA block cipher
// Fully unrolled XTEA: a chain of 2*NUM_ROUNDS half-round cells with an
// output register, taking one 64-bit word per cycle while the chain advances.
// ----------------------------------------------------------------------------
`default_nettype none

`include "xtea_block_cipher_assert.svh"

module xtea_block_cipher
    import xtea_pkg::*;
#(
    parameter int NUM_ROUNDS = XTEA_NUM_ROUNDS
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    // input word channel
    input  wire logic                      in_valid,
    output      logic                      in_stall,
    input  wire xtea_in_word_t             in_data,
    // result word channel
    output      logic                      out_valid,
    input  wire logic                      out_stall,
    output      xtea_out_word_t            out_data,
    // key write port
    input  wire logic                      cfg_wr_en,
    input  wire logic [XTEA_CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0]               cfg_data
);

    localparam int          NUM_CELLS = 2 * NUM_ROUNDS;
    // decrypt starts the running sum at delta times the round count, mod 2^32
    localparam logic [63:0] DEC_PROD  = 64'(XTEA_DELTA) * 64'(NUM_ROUNDS);
    localparam logic [31:0] DEC_SUM   = DEC_PROD[31:0];

    xtea_key_t      key_reg;
    logic           out_valid_reg;
    logic           out_valid_next;
    xtea_out_word_t out_data_reg;
    xtea_out_word_t out_data_next;

    logic           adv;
    logic           out_load;
    logic           chain_valid [NUM_CELLS+1];
    xtea_stage_t    chain_stage [NUM_CELLS+1];

    // ------------------------------------------------------------------
    // key registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_KEY_WORD0: key_reg[0] <= cfg_data;
                REG_KEY_WORD1: key_reg[1] <= cfg_data;
                REG_KEY_WORD2: key_reg[2] <= cfg_data;
                REG_KEY_WORD3: key_reg[3] <= cfg_data;
                default:       key_reg    <= key_reg;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // flow control: hold the chain only when the last cell's word can't
    // move into an occupied, stalled output register
    // ------------------------------------------------------------------
    assign out_load = !out_valid_reg || !out_stall;
    assign adv      = !(chain_valid[NUM_CELLS] && !out_load);
    assign in_stall = !adv;

    // entry of the chain: seed the running sum from the opcode
    always_comb
    begin
        chain_valid[0]        = in_valid;
        chain_stage[0].opcode = in_data.opcode;
        chain_stage[0].v0     = in_data.block_lo;
        chain_stage[0].v1     = in_data.block_hi;
        chain_stage[0].sum    = (in_data.opcode == OP_DECRYPT) ? DEC_SUM : 32'd0;
    end

    // ------------------------------------------------------------------
    // cell chain: even cells are first half-rounds, odd cells second
    // ------------------------------------------------------------------
    for (genvar i = 0; i < NUM_CELLS; i++)
    begin : g_cell
        xtea_round_cell #(
            .PHASE (1'(i % 2))
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .adv        (adv),
            .key        (key_reg),
            .prev_valid (chain_valid[i]),
            .prev_stage (chain_stage[i]),
            .cur_valid  (chain_valid[i+1]),
            .cur_stage  (chain_stage[i+1])
        );
    end

    // ------------------------------------------------------------------
    // output register: drop the word once taken, advance the next one in
    // ------------------------------------------------------------------
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (out_load)
        begin
            out_valid_next        = chain_valid[NUM_CELLS];
            out_data_next.out_lo  = chain_stage[NUM_CELLS].v0;
            out_data_next.out_hi  = chain_stage[NUM_CELLS].v1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `XTEA_ASSERT_NEXT(a_accept_enters_chain, in_valid && !in_stall, chain_valid[1],
        "accepted word did not enter the first cell")
    `XTEA_ASSERT_SAME(a_enc_sum_end,
        chain_valid[NUM_CELLS] && (chain_stage[NUM_CELLS].opcode == OP_ENCRYPT),
        chain_stage[NUM_CELLS].sum == DEC_SUM,
        "encrypt sum did not reach delta times rounds")
    `XTEA_ASSERT_SAME(a_dec_sum_end,
        chain_valid[NUM_CELLS] && (chain_stage[NUM_CELLS].opcode == OP_DECRYPT),
        chain_stage[NUM_CELLS].sum == 32'd0,
        "decrypt sum did not return to zero")
    `XTEA_ASSERT_NEXT(a_hold_keeps_last, !adv, chain_valid[NUM_CELLS] && out_valid_reg,
        "held chain lost its last word or the waiting result")

endmodule : xtea_block_cipher

`default_nettype wire
